/* sv/sdd_pkg.sv */
`default_nettype none

package sdd_pkg;

    // field widths
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int DAYNUM_W  = 23;
    localparam int DIFF_W    = 23;
    localparam int SDIFF_W   = 24;
    localparam int Q100_W    = 8;
    localparam int PROD_W    = 2 * YEAR_W;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // last valid year
    localparam int unsigned YEAR_MAX = 9999;

    // divide by 100 as multiply by reciprocal, exact for 14-bit values
    localparam int unsigned RECIP_100   = 10486;
    localparam int          RECIP_SHIFT = 20;

    // result clamp
    localparam logic signed [SDIFF_W-1:0] DIFF_LIMIT = 24'sd4194303;

    // month codes
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // stage load enables for the date unit
    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
    } date_en_t;

    // stage load enables for the difference unit
    typedef struct packed {
        logic st4;
        logic st5;
    } diff_en_t;

    // days in a common year before the first of the month
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            MON_JAN: d = 9'd0;
            MON_FEB: d = 9'd31;
            MON_MAR: d = 9'd59;
            MON_APR: d = 9'd90;
            MON_MAY: d = 9'd120;
            MON_JUN: d = 9'd151;
            MON_JUL: d = 9'd181;
            MON_AUG: d = 9'd212;
            MON_SEP: d = 9'd243;
            MON_OCT: d = 9'd273;
            MON_NOV: d = 9'd304;
            MON_DEC: d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // month length for everything but february
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        case (m)
            MON_APR, MON_JUN, MON_SEP, MON_NOV: n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* sv/sdd_date_num.sv */
`default_nettype none

module sdd_date_num
    import sdd_pkg::*;
(
    input  wire logic                aclk,
    input  wire date_en_t            en,
    input  wire logic [YEAR_W-1:0]   year,
    input  wire logic [MONTH_W-1:0]  month,
    input  wire logic [DAY_W-1:0]    day,
    output logic      [DAYNUM_W-1:0] day_num,
    output logic                     bad
);

    // stage 1: years before, reciprocal multiply, range checks
    logic [YEAR_W-1:0]  p_next;
    logic [PROD_W-1:0]  prod_next;
    logic               year_ok;
    logic               month_ok;
    logic               day_ok;
    logic               bad1_next;

    logic [YEAR_W-1:0]  p1_reg;
    logic [Q100_W-1:0]  q1_reg;
    logic [MONTH_W-1:0] m1_reg;
    logic [DAY_W-1:0]   d1_reg;
    logic               bad1_reg;

    assign p_next    = year - YEAR_W'(1);
    assign prod_next = PROD_W'(p_next) * PROD_W'(RECIP_100);

    always_comb begin
        year_ok  = (year != '0) && (32'(year) <= YEAR_MAX);
        month_ok = month inside {[MON_JAN:MON_DEC]};
        // february is checked once the leap bit is known
        day_ok   = (day != '0) && ((month == MON_FEB) || (day <= month_len(month)));
        bad1_next = !(year_ok && month_ok && day_ok);
    end

    always_ff @(posedge aclk) begin
        if (en.st1) begin
            p1_reg   <= p_next;
            q1_reg   <= prod_next[RECIP_SHIFT +: Q100_W];
            m1_reg   <= month;
            d1_reg   <= day;
            bad1_reg <= bad1_next;
        end
    end

    // stage 2: leap rule, february check, 365 * p + p / 4
    logic [YEAR_W-1:0]   q_x100;
    logic [YEAR_W-1:0]   rem100;
    logic                leap_next;
    logic                bad2_next;
    logic [DAYNUM_W-1:0] pw;
    logic [DAYNUM_W-1:0] yrs_next;

    logic [DAYNUM_W-1:0] yrs2_reg;
    logic [Q100_W-1:0]   q2_reg;
    logic                leap2_reg;
    logic [MONTH_W-1:0]  m2_reg;
    logic [DAY_W-1:0]    d2_reg;
    logic                bad2_reg;

    always_comb begin
        q_x100 = {q1_reg, 6'b0} + {1'b0, q1_reg, 5'b0} + {4'b0, q1_reg, 2'b0};
        rem100 = p1_reg - q_x100;
        // year = p + 1: divisible by 4 when p % 4 is 3, by 100 when p % 100 is 99
        leap_next = (p1_reg[1:0] == 2'b11)
                  && ((rem100 != YEAR_W'(99)) || (q1_reg[1:0] == 2'b11));
        bad2_next = bad1_reg
                  || ((m1_reg == MON_FEB) && (d1_reg > (leap_next ? 5'd29 : 5'd28)));
        pw = DAYNUM_W'(p1_reg);
        yrs_next = (pw << 8) + (pw << 6) + (pw << 5) + (pw << 3) + (pw << 2) + pw
                 + (pw >> 2);
    end

    always_ff @(posedge aclk) begin
        if (en.st2) begin
            yrs2_reg  <= yrs_next;
            q2_reg    <= q1_reg;
            leap2_reg <= leap_next;
            m2_reg    <= m1_reg;
            d2_reg    <= d1_reg;
            bad2_reg  <= bad2_next;
        end
    end

    // stage 3: century terms, month offset and day
    logic [DAYNUM_W-1:0] num_next;
    logic [DAYNUM_W-1:0] num3_reg;
    logic                bad3_reg;

    assign num_next = yrs2_reg - DAYNUM_W'(q2_reg) + DAYNUM_W'(q2_reg[Q100_W-1:2])
                    + DAYNUM_W'(days_before(m2_reg))
                    + DAYNUM_W'(leap2_reg && (m2_reg > MON_FEB))
                    + DAYNUM_W'(d2_reg);

    always_ff @(posedge aclk) begin
        if (en.st3) begin
            num3_reg <= num_next;
            bad3_reg <= bad2_reg;
        end
    end

    assign day_num = num3_reg;
    assign bad     = bad3_reg;

endmodule

`default_nettype wire

/* sv/sdd_diff.sv */
`default_nettype none

module sdd_diff
    import sdd_pkg::*;
(
    input  wire logic                aclk,
    input  wire diff_en_t            en,
    input  wire logic [DAYNUM_W-1:0] num_a,
    input  wire logic [DAYNUM_W-1:0] num_b,
    input  wire logic                bad_a,
    input  wire logic                bad_b,
    input  wire logic                end_day,
    output logic      [DIFF_W-1:0]   diff,
    output logic                     bad
);

    // stage 4: subtract day numbers
    logic signed [SDIFF_W-1:0] sub_next;
    logic signed [SDIFF_W-1:0] sub4_reg;
    logic                      bad4_reg;
    logic                      end4_reg;

    assign sub_next = $signed({1'b0, num_b}) - $signed({1'b0, num_a});

    always_ff @(posedge aclk) begin
        if (en.st4) begin
            sub4_reg <= sub_next;
            bad4_reg <= bad_a || bad_b;
            end4_reg <= end_day;
        end
    end

    // stage 5: count end day away from zero, clamp, zero on bad date
    logic signed [SDIFF_W-1:0] adj;
    logic signed [SDIFF_W-1:0] sat;
    logic        [DIFF_W-1:0]  diff_next;
    logic        [DIFF_W-1:0]  diff5_reg;
    logic                      bad5_reg;

    always_comb begin
        if (!end4_reg) begin
            adj = sub4_reg;
        end else if (sub4_reg[SDIFF_W-1]) begin
            adj = sub4_reg - SDIFF_W'(1);
        end else begin
            adj = sub4_reg + SDIFF_W'(1);
        end
        if (adj > DIFF_LIMIT) begin
            sat = DIFF_LIMIT;
        end else if (adj < -DIFF_LIMIT) begin
            sat = -DIFF_LIMIT;
        end else begin
            sat = adj;
        end
        diff_next = bad4_reg ? '0 : sat[DIFF_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en.st5) begin
            diff5_reg <= diff_next;
            bad5_reg  <= bad4_reg;
        end
    end

    assign diff = diff5_reg;
    assign bad  = bad5_reg;

endmodule

`default_nettype wire

/* sv/signed_day_difference.sv */
// an accepted input word moves through stages 1 to 5; stage 5 holds its result word in the output register
// throughput: one word per cycle while m_tready holds; the date stages run both dates side by side
// each stage moves on when it is empty or the stage after it moves, so bubbles close up
// reset: synchronous active-low aresetn clears all stage valid bits; data registers keep
// their contents, and no word is pending after reset
`default_nettype none

module signed_day_difference
    import sdd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // first_year, first_month, first_day, second_year, second_month, second_day,
    // count_end_day, one zero pad bit
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // day_difference, one zero pad bit
    output logic      [M_TDATA_W-1:0] m_tdata,
    // bad_date
    output logic                      m_tuser
);

    // unpack input word
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
    logic               count_end_day;

    assign first_year    = s_tdata[13:0];
    assign first_month   = s_tdata[17:14];
    assign first_day     = s_tdata[22:18];
    assign second_year   = s_tdata[36:23];
    assign second_month  = s_tdata[40:37];
    assign second_day    = s_tdata[45:41];
    assign count_end_day = s_tdata[46];

    // stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || m_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // end day flag rides along with the date stages
    logic end1_reg, end2_reg, end3_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) end1_reg <= count_end_day;
        if (rdy2) end2_reg <= end1_reg;
        if (rdy3) end3_reg <= end2_reg;
    end

    // day numbers of both dates
    date_en_t            date_en;
    diff_en_t            diff_en;
    logic [DAYNUM_W-1:0] num_a, num_b;
    logic                bad_a, bad_b;
    logic [DIFF_W-1:0]   diff;
    logic                bad;

    assign date_en = '{st1: rdy1, st2: rdy2, st3: rdy3};
    assign diff_en = '{st4: rdy4, st5: rdy5};

    sdd_date_num u_date_a (
        .aclk    (aclk),
        .en      (date_en),
        .year    (first_year),
        .month   (first_month),
        .day     (first_day),
        .day_num (num_a),
        .bad     (bad_a)
    );

    sdd_date_num u_date_b (
        .aclk    (aclk),
        .en      (date_en),
        .year    (second_year),
        .month   (second_month),
        .day     (second_day),
        .day_num (num_b),
        .bad     (bad_b)
    );

    // subtract, count end day, clamp
    sdd_diff u_diff (
        .aclk    (aclk),
        .en      (diff_en),
        .num_a   (num_a),
        .num_b   (num_b),
        .bad_a   (bad_a),
        .bad_b   (bad_b),
        .end_day (end3_reg),
        .diff    (diff),
        .bad     (bad)
    );

    // output word
    assign s_tready = rdy1;
    assign m_tvalid = v5_reg;
    assign m_tdata  = {1'b0, diff};
    assign m_tuser  = bad;

`ifndef NO_ASSERTIONS
    // a bad date always reports a zero difference
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[DIFF_W-1:0] == '0))
        else $error("bad date word carries a nonzero difference");

    // clamp never yields the most negative code
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DIFF_W-1:0] != {1'b1, {(DIFF_W-1){1'b0}}}))
        else $error("difference outside the clamp range");

    // an empty output register means the whole pipe can take a word
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output register is empty");

    // a word moving out of stage 4 shows up at the output next cycle
    a_stage4_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && rdy5) |=> m_tvalid)
        else $error("word lost between stage 4 and the output");
`endif

endmodule

`default_nettype wire
